// ===== sv/stkt_pkg.sv =====
// Package for the sorted time key table: sizes, codes, entry layout and key function.
// Used by sorted_time_key_table_top and stkt_checker; depends on nothing.
package stkt_pkg;

  localparam int CAPACITY   = 16;
  localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int ENTRY_W    = 43;
  localparam int COUNT_W    = 5;
  localparam int KEY_W      = 32;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;
  localparam int IN_USER_W  = 2;
  localparam int OUT_USER_W = 3;

  localparam logic [IN_USER_W-1:0] OP_ADD    = 2'd0;
  localparam logic [IN_USER_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [IN_USER_W-1:0] OP_LIST   = 2'd2;

  localparam logic [OUT_USER_W-1:0] ST_DONE         = 3'd0;
  localparam logic [OUT_USER_W-1:0] ST_FULL         = 3'd1;
  localparam logic [OUT_USER_W-1:0] ST_NONE_REMOVED = 3'd2;
  localparam logic [OUT_USER_W-1:0] ST_LISTED       = 3'd3;
  localparam logic [OUT_USER_W-1:0] ST_EMPTY        = 3'd4;

  // first member in the highest bits, so year sits at bit 0
  typedef struct packed {
    logic [5:0]  end_minute;
    logic [4:0]  end_hour;
    logic [5:0]  start_minute;
    logic [4:0]  start_hour;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } entry_t;

  function automatic logic [KEY_W-1:0] key_of(entry_t e);
    logic [10:0] mins;
    mins = 11'(e.start_hour) * 11'd60 + 11'(e.start_minute);
    return {e.year, e.month, e.day, mins};
  endfunction

endpackage

// ===== sv/sorted_time_key_table_top.sv =====
// Sorted time key table: top level with sequencer, entry store and shared key comparator.
// Depends on stkt_pkg.
//
// Holds up to CAPACITY entries in ascending order of (year, month, day, start minutes).
// One operation is taken at a time; in_tready is high only while the block is idle.
// Every cycle reads one entry through a single read port and one key comparator, so:
// add shifts each larger entry up one slot, then writes the new one; remove walks
// all entries, packing kept ones down; list sends a beat per entry, stalled by out_tready.
// A finished result beat waits in the output register while the sequencer goes on.
module sorted_time_key_table_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // year, month, day, start_hour, start_minute, end_hour, end_minute, zero pad
  input  logic [stkt_pkg::IN_DATA_W-1:0]      in_tdata,
  // func
  input  logic [stkt_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // out_year, out_month, out_day, out_start_hour, out_start_minute,
  // out_end_hour, out_end_minute, entry_count
  output logic [stkt_pkg::OUT_DATA_W-1:0]     out_tdata,
  // status
  output logic [stkt_pkg::OUT_USER_W-1:0]     out_tuser,
  output logic                                out_tlast
);

  typedef enum logic [1:0] {S_IDLE, S_ADD, S_REM, S_LIST} state_t;

  state_t                               state_r;
  stkt_pkg::entry_t                     entries_r [stkt_pkg::CAPACITY];
  logic [stkt_pkg::CNT_W-1:0]           fill_r;
  logic [stkt_pkg::CNT_W-1:0]           idx_r;
  logic [stkt_pkg::CNT_W-1:0]           kept_r;
  stkt_pkg::entry_t                     new_r;
  logic [stkt_pkg::KEY_W-1:0]           new_key_r;
  logic                                 out_valid_r;
  logic                                 out_valid_nxt;
  stkt_pkg::entry_t                     out_entry_r;
  logic [stkt_pkg::COUNT_W-1:0]         out_count_r;
  logic [stkt_pkg::OUT_USER_W-1:0]      out_status_r;
  logic                                 out_last_r;

  logic [stkt_pkg::IDX_W-1:0]           rd_addr;
  stkt_pkg::entry_t                     rd_entry;
  logic [stkt_pkg::KEY_W-1:0]           rd_key;
  logic                                 key_lt;
  logic                                 key_eq;
  logic                                 slot_free;
  stkt_pkg::entry_t                     in_entry;
  logic                                 list_last;

  assign in_entry   = stkt_pkg::entry_t'(in_tdata[stkt_pkg::ENTRY_W-1:0]);
  assign rd_addr    = (state_r == S_ADD) ? stkt_pkg::IDX_W'(idx_r - 1'b1)
                                         : idx_r[stkt_pkg::IDX_W-1:0];
  assign rd_entry   = entries_r[rd_addr];
  assign rd_key     = stkt_pkg::key_of(rd_entry);
  assign key_lt     = new_key_r < rd_key;
  assign key_eq     = new_key_r == rd_key;
  assign slot_free  = !out_valid_r || out_tready;
  assign list_last  = stkt_pkg::CNT_W'(idx_r + 1'b1) == fill_r;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_entry_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_ADD: begin
        if (slot_free && (fill_r >= stkt_pkg::CNT_W'(stkt_pkg::CAPACITY) ||
                          !(idx_r != '0 && key_lt))) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_REM: begin
        if (slot_free && idx_r == fill_r) begin
          out_valid_nxt = 1'b1;
        end
      end
      S_LIST: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      idx_r       <= '0;
      kept_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            new_r     <= in_entry;
            new_key_r <= stkt_pkg::key_of(in_entry);
            kept_r    <= '0;
            unique case (in_tuser)
              stkt_pkg::OP_ADD: begin
                idx_r   <= fill_r;
                state_r <= S_ADD;
              end
              stkt_pkg::OP_REMOVE: begin
                idx_r   <= '0;
                state_r <= S_REM;
              end
              stkt_pkg::OP_LIST: begin
                idx_r   <= '0;
                state_r <= S_LIST;
              end
              default: state_r <= S_IDLE;
            endcase
          end
        end
        S_ADD: begin
          if (fill_r >= stkt_pkg::CNT_W'(stkt_pkg::CAPACITY)) begin
            if (slot_free) begin
              out_status_r <= stkt_pkg::ST_FULL;
              out_entry_r  <= '0;
              out_count_r  <= stkt_pkg::COUNT_W'(fill_r);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else if (idx_r != '0 && key_lt) begin
            entries_r[idx_r[stkt_pkg::IDX_W-1:0]] <= rd_entry;
            idx_r <= idx_r - 1'b1;
          end else if (slot_free) begin
            entries_r[idx_r[stkt_pkg::IDX_W-1:0]] <= new_r;
            fill_r       <= fill_r + 1'b1;
            out_status_r <= stkt_pkg::ST_DONE;
            out_entry_r  <= '0;
            out_count_r  <= stkt_pkg::COUNT_W'(fill_r + 1'b1);
            out_last_r   <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        S_REM: begin
          if (idx_r == fill_r) begin
            if (slot_free) begin
              fill_r       <= kept_r;
              out_status_r <= (kept_r != fill_r) ? stkt_pkg::ST_DONE
                                                 : stkt_pkg::ST_NONE_REMOVED;
              out_entry_r  <= '0;
              out_count_r  <= stkt_pkg::COUNT_W'(kept_r);
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end
          end else begin
            if (!key_eq) begin
              entries_r[kept_r[stkt_pkg::IDX_W-1:0]] <= rd_entry;
              kept_r <= kept_r + 1'b1;
            end
            idx_r <= idx_r + 1'b1;
          end
        end
        S_LIST: begin
          if (slot_free) begin
            out_count_r <= stkt_pkg::COUNT_W'(fill_r);
            if (fill_r == '0) begin
              out_status_r <= stkt_pkg::ST_EMPTY;
              out_entry_r  <= '0;
              out_last_r   <= 1'b1;
              state_r      <= S_IDLE;
            end else begin
              out_status_r <= stkt_pkg::ST_LISTED;
              out_entry_r  <= rd_entry;
              out_last_r   <= list_last;
              idx_r        <= idx_r + 1'b1;
              if (list_last) begin
                state_r <= S_IDLE;
              end
            end
          end
        end
      endcase
    end
  end

endmodule

// ===== sv/stkt_checker.sv =====
// Port-level checker for sorted_time_key_table_top, attached by bind.
// Depends on stkt_pkg.
module stkt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [stkt_pkg::IN_USER_W-1:0]    in_tuser,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [stkt_pkg::OUT_DATA_W-1:0]   out_tdata,
  input logic [stkt_pkg::OUT_USER_W-1:0]   out_tuser,
  input logic                              out_tlast
);

  // hold a stalled result beat
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("stalled result beat changed");

  // busy after a real operation is taken
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser == stkt_pkg::OP_ADD ||
      in_tuser == stkt_pkg::OP_REMOVE || in_tuser == stkt_pkg::OP_LIST) |=> !in_tready)
    else $error("input taken while an operation is in progress");

  // non-list beats carry no entry and close the operation
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != stkt_pkg::ST_LISTED |->
      out_tlast && out_tdata[stkt_pkg::ENTRY_W-1:0] == '0)
    else $error("status beat with entry data or without last");

  // a listed entry implies a non-empty table
  a_listed_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == stkt_pkg::ST_LISTED |->
      out_tdata[stkt_pkg::OUT_DATA_W-1:stkt_pkg::ENTRY_W] != '0)
    else $error("listed entry with zero count");

  // status stays within its codes
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == stkt_pkg::ST_DONE || out_tuser == stkt_pkg::ST_FULL ||
      out_tuser == stkt_pkg::ST_NONE_REMOVED || out_tuser == stkt_pkg::ST_LISTED ||
      out_tuser == stkt_pkg::ST_EMPTY)
    else $error("unknown status code");

endmodule

bind sorted_time_key_table_top stkt_checker u_stkt_checker (.*);
